@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the RTL. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/dmn_pkg.sv @@
// ---------------------------------------------------------------------------
// dmn_pkg
// Types and codes shared by the mutual exclusion node and its output stage.
// ---------------------------------------------------------------------------
package dmn_pkg;

	localparam int ID_W      = 5;
	localparam int SEQ_W     = 16;
	localparam int FUNC_W    = 2;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 5;

	// Number of node slots. The id and destination fields are sized for it.
	localparam int NODE_SLOTS = 16;

	// Event codes.
	localparam logic [FUNC_W-1:0] FUNC_WANT       = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PEER_REQ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEER_REPLY = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 2'd3;

	// Message kinds.
	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   peer;
		logic [SEQ_W-1:0]  peer_seq;
	} evt_t;

	typedef struct packed {
		logic [KIND_W-1:0] msg_kind;
		logic [ID_W-1:0]   dest;
		logic [SEQ_W-1:0]  out_seq;
		logic              last;
	} msg_t;

endpackage

@@ hdl/dmn_outbuf.sv @@
// ---------------------------------------------------------------------------
// dmn_outbuf
// Output register of the node: holds one message until the receiver takes it.
// ---------------------------------------------------------------------------
module dmn_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  dmn_pkg::msg_t din,
	output logic          free,
	output logic          msg_valid,
	input  logic          msg_ready,
	output dmn_pkg::msg_t msg
);
	import dmn_pkg::*;

	logic valid_q;
	msg_t data_q;

	// The register can take a new message when empty or when it drains now.
	assign free      = !valid_q || msg_ready;
	assign msg_valid = valid_q;
	assign msg       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (msg_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

@@ hdl/distributed_mutex_node.sv @@
// ---------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala distributed mutual exclusion.
// ---------------------------------------------------------------------------
// Usage. Events enter on the evt channel (valid/ready): want entry, peer
// request, peer reply and release. Every message the node must send leaves on
// the msg channel (valid/ready), one transaction per message, with last set
// on the final message caused by an event. The user must write node_count
// and own_id on the cfg channel only while idle; it is not enforced.
//
// Timing. Peer requests, peer replies and a want entry that needs no request
// are handled as the event is taken; their message, if any, is shown the
// cycle after. A want entry with peers, and a release with deferred replies,
// start a walk over the id positions: one position per cycle while the output
// can take a message, from node 1 up to the highest id that gets a message,
// so at most NODE_SLOTS positions. A single scan unit (mask, index counter,
// one compare) does the walk; the node takes no new event until it finishes.
//
// Reset clears all protocol state: not requesting, sequence numbers zero,
// nothing deferred, node_count = 2 and own_id = 1. When the receiver stalls,
// the output register holds its message and the walk pauses on it; the
// node keeps evt_ready low until the register can take a message again.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module distributed_mutex_node (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             evt_valid,
	output logic                             evt_ready,
	input  dmn_pkg::evt_t                    evt,
	output logic                             msg_valid,
	input  logic                             msg_ready,
	output dmn_pkg::msg_t                    msg,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dmn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dmn_pkg::CFG_W-1:0]        cfg_data
);
	import dmn_pkg::*;

	localparam int IDX_W  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int OWED_W = IDX_W;

	// Sequencer states: idle, or walking a mask of destinations.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	// Configuration.
	logic [ID_W-1:0] node_count_q;
	logic [ID_W-1:0] own_id_q;

	// Protocol state.
	logic                  requesting_q, requesting_n;
	logic [SEQ_W-1:0]      own_seq_q, own_seq_n;
	logic [SEQ_W-1:0]      highest_q, highest_n;
	logic [OWED_W-1:0]     owed_q, owed_n;
	logic [NODE_SLOTS-1:0] deferred_q, deferred_n;

	// Scan unit: remaining destinations, current position and message kind.
	logic                  state_q, state_n;
	logic [NODE_SLOTS-1:0] rem_q, rem_n;
	logic [IDX_W-1:0]      idx_q, idx_n;
	logic [KIND_W-1:0]     kind_q, kind_n;

	// Output register interface.
	logic obuf_load;
	msg_t obuf_din;
	logic obuf_free;

	// Decoded helpers.
	logic [ID_W:0]         n_eff;
	logic                  me_in_range;
	logic                  peer_ok;
	logic                  defer;
	logic [NODE_SLOTS-1:0] in_range;
	logic [NODE_SLOTS-1:0] own_onehot;
	logic [NODE_SLOTS-1:0] peer_onehot;
	logic [NODE_SLOTS-1:0] idx_onehot;
	logic [NODE_SLOTS-1:0] bc_mask;
	logic [NODE_SLOTS-1:0] flush_mask;
	logic [NODE_SLOTS-1:0] rem_rest;
	logic                  evt_fire;

	assign evt_ready = (state_q == ST_IDLE) && obuf_free;
	assign cfg_ready = 1'b1;
	assign evt_fire  = evt_valid && evt_ready;

	// The effective node count is node_count clamped to NODE_SLOTS.
	always_comb begin
		if ({1'b0, node_count_q} > (ID_W+1)'(NODE_SLOTS)) begin
			n_eff = (ID_W+1)'(NODE_SLOTS);
		end else begin
			n_eff = {1'b0, node_count_q};
		end
	end

	assign me_in_range = (own_id_q != '0) && ({1'b0, own_id_q} <= n_eff);
	assign peer_ok = (evt.peer != '0) && ({1'b0, evt.peer} <= n_eff) &&
		(evt.peer != own_id_q);
	// A peer with a later sequence, or the same sequence and a larger id,
	// waits for our release.
	assign defer = requesting_q && ((evt.peer_seq > own_seq_q) ||
		((evt.peer_seq == own_seq_q) && (evt.peer > own_id_q)));

	// Bit k of every mask stands for node k+1.
	always_comb begin
		for (int k = 0; k < NODE_SLOTS; k++) begin
			in_range[k]    = ((ID_W+1)'(k) < n_eff);
			own_onehot[k]  = ((ID_W+1)'(k) + (ID_W+1)'(1) == {1'b0, own_id_q});
			peer_onehot[k] = ((ID_W+1)'(k) + (ID_W+1)'(1) == {1'b0, evt.peer});
			idx_onehot[k]  = (IDX_W'(k) == idx_q);
		end
	end

	// Broadcast targets. With own_id outside the node range and a full node
	// count, the top node is dropped so that at most NODE_SLOTS-1 requests go.
	always_comb begin
		bc_mask = in_range & ~own_onehot;
		if (!me_in_range && (n_eff == (ID_W+1)'(NODE_SLOTS))) begin
			bc_mask[NODE_SLOTS-1] = 1'b0;
		end
	end

	assign flush_mask = deferred_q & ~own_onehot;
	assign rem_rest   = rem_q & ~idx_onehot;

	// Sequencer and protocol next-state logic.
	always_comb begin
		requesting_n = requesting_q;
		own_seq_n    = own_seq_q;
		highest_n    = highest_q;
		owed_n       = owed_q;
		deferred_n   = deferred_q;
		state_n      = state_q;
		rem_n        = rem_q;
		idx_n        = idx_q;
		kind_n       = kind_q;
		obuf_load    = 1'b0;
		obuf_din     = '0;

		case (state_q)
			ST_IDLE: begin
				if (evt_fire) begin
					case (evt.func)
						FUNC_WANT: begin
							if (!requesting_q) begin
								requesting_n = 1'b1;
								own_seq_n    = highest_q + SEQ_W'(1);
								owed_n       = '0;
								if (bc_mask == '0) begin
									// No peer at all: enter at once.
									obuf_load         = 1'b1;
									obuf_din.msg_kind = KIND_GRANT;
									obuf_din.last     = 1'b1;
								end else begin
									rem_n   = bc_mask;
									idx_n   = '0;
									kind_n  = KIND_REQUEST;
									state_n = ST_WALK;
								end
							end
						end
						FUNC_PEER_REQ: begin
							if (peer_ok) begin
								if (evt.peer_seq > highest_q) begin
									highest_n = evt.peer_seq;
								end
								if (defer) begin
									deferred_n = deferred_q | peer_onehot;
								end else begin
									obuf_load         = 1'b1;
									obuf_din.msg_kind = KIND_REPLY;
									obuf_din.dest     = evt.peer;
									obuf_din.last     = 1'b1;
								end
							end
						end
						FUNC_PEER_REPLY: begin
							if (requesting_q && (owed_q != '0)) begin
								owed_n = owed_q - OWED_W'(1);
								if (owed_q == OWED_W'(1)) begin
									obuf_load         = 1'b1;
									obuf_din.msg_kind = KIND_GRANT;
									obuf_din.last     = 1'b1;
								end
							end
						end
						FUNC_RELEASE: begin
							requesting_n = 1'b0;
							owed_n       = '0;
							deferred_n   = '0;
							rem_n        = flush_mask;
							idx_n        = '0;
							kind_n       = KIND_REPLY;
							if (flush_mask != '0) begin
								state_n = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				// One id position per cycle, paused while the output is full.
				if (obuf_free) begin
					if (rem_q[idx_q]) begin
						obuf_load         = 1'b1;
						obuf_din.msg_kind = kind_q;
						obuf_din.dest     = ID_W'(idx_q) + ID_W'(1);
						obuf_din.out_seq  = (kind_q == KIND_REQUEST) ? own_seq_q : '0;
						obuf_din.last     = (rem_rest == '0);
						if (kind_q == KIND_REQUEST) begin
							owed_n = owed_q + OWED_W'(1);
						end
					end
					rem_n = rem_rest;
					idx_n = idx_q + IDX_W'(1);
					if (rem_rest == '0) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			requesting_q <= 1'b0;
			own_seq_q    <= '0;
			highest_q    <= '0;
			owed_q       <= '0;
			deferred_q   <= '0;
			state_q      <= ST_IDLE;
			rem_q        <= '0;
			idx_q        <= '0;
		end else begin
			requesting_q <= requesting_n;
			own_seq_q    <= own_seq_n;
			highest_q    <= highest_n;
			owed_q       <= owed_n;
			deferred_q   <= deferred_n;
			state_q      <= state_n;
			rem_q        <= rem_n;
			idx_q        <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_n;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= ID_W'(2);
			own_id_q     <= ID_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_OWN_ID:     own_id_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dmn_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (obuf_load),
		.din       (obuf_din),
		.free      (obuf_free),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg)
	);

	// The output register is loaded only when it can take the message.
	`ASSERT_IMPL(a_load_when_free, clk, arst_n, obuf_load, obuf_free)
	// A walk always has at least one destination left.
	`ASSERT_IMPL(a_walk_nonempty, clk, arst_n, state_q == ST_WALK, rem_q != '0)
	// Replies are only owed while a request is pending.
	`ASSERT_IMPL(a_owed_needs_req, clk, arst_n, !requesting_q, owed_q == '0)
	// Entry is granted only to a requesting node.
	`ASSERT_NEXT(a_grant_requesting, clk, arst_n,
		obuf_load && (obuf_din.msg_kind == KIND_GRANT), requesting_q)

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for one node of Ricart-Agrawala mutual exclusion. It
// feeds event transactions, computes the messages the node must send, and
// checks every message transaction against them in order. The run moves
// through several node_count / own_id settings. Each setting gets some
// directed events or random protocol episodes, with random stalls on both
// channels in most settings.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dmn_pkg::*;

	// A walk covers at most NODE_SLOTS positions. This margin is enough for the
	// node to finish any event that produces no message.
	localparam int DRAIN       = 40;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 evt_valid = 1'b0;
	logic                 evt_ready;
	evt_t                 evt = '0;
	logic                 msg_valid;
	logic                 msg_ready = 1'b0;
	msg_t                 msg;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	distributed_mutex_node u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Events that the stimulus has planned and the driver has not yet
	// presented. The other queue holds the messages that the node still owes.
	evt_t evts_todo[$];
	msg_t msgs_due[$];

	// These flags record whether a transaction completed at the last rising
	// edge. The drivers and the stimulus read them at the falling edge.
	logic evt_acc = 1'b0;
	logic cfg_acc = 1'b0;

	// This is the chance, in percent, that either side starts an idle burst.
	// Zero gives a stretch with no idling.
	int unsigned idle_pct = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_hold = 0;

	int unsigned faults = 0;
	int unsigned cycle_count = 0;
	msg_t        due_head;

	// The predictor keeps its own copy of the registers and protocol state.
	logic [CFG_W-1:0]      nodes_cfg = 5'd2;
	logic [CFG_W-1:0]      me_cfg = 5'd1;
	logic                  in_request = 1'b0;
	logic [SEQ_W-1:0]      my_seq = '0;
	logic [SEQ_W-1:0]      top_seq = '0;
	logic [ID_W-1:0]       owed = '0;
	logic [NODE_SLOTS-1:0] held = '0;

	// The stimulus tracks the setting and the sequence numbers it has planned.
	// This lets it build well-formed episodes ahead of the driver.
	logic [CFG_W-1:0] plan_nodes = 5'd2;
	logic [CFG_W-1:0] plan_me = 5'd1;
	logic [SEQ_W-1:0] plan_hi = '0;
	logic [SEQ_W-1:0] plan_seq = '0;
	logic             plan_busy = 1'b0;

	function automatic msg_t make_msg(input logic [KIND_W-1:0] kind, input int unsigned dest,
			input logic [SEQ_W-1:0] seq);
		msg_t m;
		m.msg_kind = kind;
		m.dest     = ID_W'(dest);
		m.out_seq  = seq;
		m.last     = 1'b0;
		return m;
	endfunction

	// Apply one accepted event to the predicted node state. Queue the messages
	// that the event causes, and flag the final one with last.
	task automatic compute_messages(input evt_t e);
		msg_t        burst[$];
		int unsigned n;
		n = (nodes_cfg > NODE_SLOTS) ? NODE_SLOTS : nodes_cfg;
		case (e.func)
		FUNC_WANT: begin
			// A second wish while a request is pending has no effect.
			if (!in_request) begin
				in_request = 1'b1;
				my_seq = top_seq + 16'd1;
				for (int j = 1; j <= n && burst.size() < NODE_SLOTS - 1; j++) begin
					if (j != me_cfg)
						burst.push_back(make_msg(KIND_REQUEST, j, my_seq));
				end
				owed = ID_W'(burst.size());
				// With no peer at all, the node may enter at once.
				if (burst.size() == 0)
					burst.push_back(make_msg(KIND_GRANT, 0, '0));
			end
		end
		FUNC_PEER_REQ: begin
			// A request from id 0, from beyond the node count or from this
			// node is dropped without touching the highest sequence seen.
			if (e.peer != 0 && e.peer <= n && e.peer != me_cfg) begin
				if (e.peer_seq > top_seq)
					top_seq = e.peer_seq;
				if (in_request && (e.peer_seq > my_seq ||
						(e.peer_seq == my_seq && e.peer > me_cfg)))
					held[e.peer - 1] = 1'b1;
				else
					burst.push_back(make_msg(KIND_REPLY, e.peer, '0));
			end
		end
		FUNC_PEER_REPLY: begin
			if (in_request && owed != 0) begin
				owed = owed - 1'b1;
				if (owed == 0)
					burst.push_back(make_msg(KIND_GRANT, 0, '0));
			end
		end
		default: begin
			// Release: flush deferred replies. The bit of this node's own id
			// is dropped without a reply.
			in_request = 1'b0;
			owed = '0;
			for (int j = 1; j <= NODE_SLOTS; j++) begin
				if (held[j-1]) begin
					held[j-1] = 1'b0;
					if (j != me_cfg)
						burst.push_back(make_msg(KIND_REPLY, j, '0));
				end
			end
		end
		endcase
		if (burst.size() != 0)
			burst[burst.size()-1].last = 1'b1;
		foreach (burst[k])
			msgs_due.push_back(burst[k]);
	endtask

	// Everything happens on the rising edge. The bench first checks a message
	// transaction against the oldest prediction, then updates the registers,
	// then runs the predictor. An event's messages appear only after it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			evt_acc <= evt_valid && evt_ready;
			cfg_acc <= cfg_valid && cfg_ready;
			if (msg_valid && msg_ready) begin
				if (msgs_due.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected message: kind %0d dest %0d seq %0d last %0d",
							msg.msg_kind, msg.dest, msg.out_seq, msg.last);
				end else begin
					due_head = msgs_due.pop_front();
					if (msg.msg_kind !== due_head.msg_kind || msg.dest !== due_head.dest ||
							msg.out_seq !== due_head.out_seq || msg.last !== due_head.last) begin
						faults++;
						if (faults <= 10)
							$display("message mismatch: expected kind %0d dest %0d seq %0d last %0d, got kind %0d dest %0d seq %0d last %0d",
								due_head.msg_kind, due_head.dest, due_head.out_seq,
								due_head.last, msg.msg_kind, msg.dest, msg.out_seq, msg.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_NODE_COUNT: nodes_cfg = cfg_data;
				CFG_OWN_ID:     me_cfg = cfg_data;
				default: ;
				endcase
			end
			if (evt_valid && evt_ready)
				compute_messages(evt);
		end
	end

	// Event driver. Once valid is up, it holds valid and the payload until the
	// transaction completes. When the channel is free, it starts an idle burst
	// or presents the next planned event.
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else if (!evt_valid || evt_acc) begin
			if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
				evt_valid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				tx_gap <= $urandom_range(11);
				evt_valid <= 1'b0;
			end else if (evts_todo.size() != 0) begin
				evt <= evts_todo.pop_front();
				evt_valid <= 1'b1;
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// Message receiver. It stalls in random bursts.
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			msg_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			rx_hold <= $urandom_range(11);
			msg_ready <= 1'b0;
		end else begin
			msg_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned plan_n();
		return (plan_nodes > NODE_SLOTS) ? NODE_SLOTS : plan_nodes;
	endfunction

	// Pick a sender that the node accepts. If the setting has no valid peer,
	// any id will do.
	function automatic logic [ID_W-1:0] pick_peer();
		int unsigned n;
		int unsigned p;
		n = plan_n();
		if (n == 0 || (n == 1 && plan_me == 1))
			return ID_W'($urandom);
		do
			p = $urandom_range(n, 1);
		while (p == plan_me);
		return ID_W'(p);
	endfunction

	// Most peer sequence numbers sit close to this node's own number, so the
	// priority compare sees ties and near misses.
	function automatic logic [SEQ_W-1:0] pick_seq();
		int unsigned r;
		r = $urandom_range(15);
		if (r < 3)
			return plan_seq - 16'd1;
		else if (r < 8)
			return plan_seq;
		else if (r < 11)
			return plan_seq + 16'd1;
		else if (r < 15)
			return plan_hi + SEQ_W'($urandom_range(3));
		return SEQ_W'($urandom);
	endfunction

	task automatic push_evt(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] p,
			input logic [SEQ_W-1:0] s);
		evt_t e;
		e.func     = f;
		e.peer     = p;
		e.peer_seq = s;
		evts_todo.push_back(e);
		case (f)
		FUNC_WANT: begin
			if (!plan_busy) begin
				plan_busy = 1'b1;
				plan_seq = plan_hi + 16'd1;
			end
		end
		FUNC_PEER_REQ: begin
			if (p != 0 && p <= plan_n() && p != plan_me && s > plan_hi)
				plan_hi = s;
		end
		FUNC_RELEASE: plan_busy = 1'b0;
		default: ;
		endcase
	endtask

	// One round of the protocol. A wish is followed by the replies it needs,
	// mixed with peer requests and some noise. Now and then the round is cut
	// short. A few requests arrive while this node holds entry. A release
	// closes the round.
	task automatic add_episode(inout int made);
		int unsigned left;
		int unsigned r;
		left = 0;
		for (int j = 1; j <= plan_n() && left < NODE_SLOTS - 1; j++) begin
			if (j != plan_me)
				left++;
		end
		push_evt(FUNC_WANT, ID_W'($urandom), SEQ_W'($urandom));
		made++;
		while (left != 0) begin
			r = $urandom_range(11);
			if (r < 6) begin
				push_evt(FUNC_PEER_REPLY, ID_W'($urandom), SEQ_W'($urandom));
				left--;
				made++;
			end else if (r < 9) begin
				push_evt(FUNC_PEER_REQ, pick_peer(), pick_seq());
				made++;
			end else if (r < 11) begin
				push_evt(FUNC_W'($urandom), ID_W'($urandom), SEQ_W'($urandom));
				made++;
			end else if ($urandom_range(3) == 0) begin
				left = 0;
			end
		end
		repeat ($urandom_range(3)) begin
			push_evt(FUNC_PEER_REQ, pick_peer(), pick_seq());
			made++;
		end
		if ($urandom_range(3) == 0) begin
			push_evt(FUNC_PEER_REPLY, ID_W'($urandom), SEQ_W'($urandom));
			made++;
		end
		push_evt(FUNC_RELEASE, ID_W'($urandom), SEQ_W'($urandom));
		made++;
	endtask

	task automatic add_traffic(input int budget);
		int made;
		made = 0;
		while (made < budget) begin
			repeat ($urandom_range(2)) begin
				push_evt(FUNC_PEER_REQ, pick_peer(), pick_seq());
				made++;
			end
			add_episode(made);
		end
	endtask

	// Write one register. This task leaves valid high, so a second write can
	// follow at once. The caller lowers valid after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(negedge clk);
		while (!cfg_acc);
	endtask

	// Hold back the sender until the node owes nothing, then give a walk time
	// to end. This allows for an event that produced no message. The check
	// runs just after the falling edge, once the driver's updates have landed.
	task automatic settle();
		do begin
			@(negedge clk);
			#1;
		end while (evts_todo.size() != 0 || evt_valid || msgs_due.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic start_phase(input logic [CFG_W-1:0] nc, input logic [CFG_W-1:0] id,
			input int unsigned pct);
		settle();
		write_reg(CFG_NODE_COUNT, nc);
		write_reg(CFG_OWN_ID, id);
		cfg_valid <= 1'b0;
		plan_nodes = nc;
		plan_me = id;
		// New events are queued at a rising edge, away from the driver.
		@(posedge clk);
		idle_pct = pct;
	endtask

	initial begin
		int unsigned guard;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed events with four nodes, and this node as id 2.
		start_phase(5'd4, 5'd2, 20);
		push_evt(FUNC_RELEASE, 5'd0, 16'd0);            // nothing to flush
		push_evt(FUNC_PEER_REPLY, 5'd1, 16'd0);         // stray reply, idle
		push_evt(FUNC_PEER_REQ, 5'd0, 16'd7);           // sender id 0
		push_evt(FUNC_PEER_REQ, 5'd5, 16'd9);           // sender above count
		push_evt(FUNC_PEER_REQ, 5'd2, 16'd9);           // sender is this node
		push_evt(FUNC_PEER_REQ, 5'd31, 16'hFFFF);       // all ones, dropped
		push_evt(FUNC_PEER_REQ, 5'd1, 16'hFFFF);        // reply; highest at max
		push_evt(FUNC_WANT, 5'd0, 16'd0);               // own sequence wraps to 0
		push_evt(FUNC_WANT, 5'd31, 16'hFFFF);           // already requesting
		push_evt(FUNC_PEER_REQ, 5'd3, 16'd0);           // tie, larger id: deferred
		push_evt(FUNC_PEER_REQ, 5'd1, 16'd0);           // tie, smaller id: reply
		push_evt(FUNC_PEER_REQ, 5'd4, 16'd1);           // larger sequence: deferred
		push_evt(FUNC_PEER_REPLY, 5'd31, 16'hFFFF);
		push_evt(FUNC_PEER_REPLY, 5'd0, 16'd0);
		push_evt(FUNC_PEER_REPLY, 5'd3, 16'd0);         // last one owed: grant
		push_evt(FUNC_PEER_REPLY, 5'd1, 16'd0);         // nothing owed any more
		push_evt(FUNC_RELEASE, 5'd31, 16'hFFFF);        // replies to 3 and 4
		push_evt(FUNC_RELEASE, 5'd0, 16'd0);

		// Full node set, with this node at the top id.
		start_phase(5'd16, 5'd16, 20);
		add_traffic(85);
		// Leave nodes 3 and 12 deferred. The next setting then makes 3 this
		// node's own id and drops 12 out of range. On release, only 12 is
		// answered.
		push_evt(FUNC_WANT, 5'd0, 16'd0);
		push_evt(FUNC_PEER_REQ, 5'd3, plan_seq + 16'd5);
		push_evt(FUNC_PEER_REQ, 5'd12, plan_seq + 16'd7);

		start_phase(5'd5, 5'd3, 30);
		push_evt(FUNC_RELEASE, 5'd0, 16'd0);
		add_traffic(60);

		// With no peer, a wish grants entry at once. This stretch runs
		// without idling.
		start_phase(5'd1, 5'd1, 0);
		add_traffic(15);
		start_phase(5'd0, 5'd31, 0);
		add_traffic(10);

		start_phase(5'd2, 5'd2, 25);
		add_traffic(50);

		// Count above the maximum, own id outside the range. Requests stop
		// after fifteen peers, so node 16 gets none.
		start_phase(5'd31, 5'd0, 15);
		add_traffic(60);

		start_phase(5'd9, 5'd20, 10);
		add_traffic(50);

		// The final part runs without idling on either side.
		start_phase(5'd16, 5'd1, 0);
		add_traffic(70);

		do begin
			@(negedge clk);
			#1;
		end while (evts_todo.size() != 0 || evt_valid);
		guard = 0;
		while (msgs_due.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN) @(negedge clk);
		if (msgs_due.size() != 0) begin
			faults++;
			$display("%0d expected messages never arrived", msgs_due.size());
		end

		if (faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
